FILE: hdl/assert_macros.svh
// Assertion macros shared by the z-base-32 encoder modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ZB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ZB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/zb32e_pkg.sv
// Shared types and constants of the z-base-32 bit-length encoder.
// No dependencies.
package zb32e_pkg;

  // Input transaction: one message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
    logic [3:0] last_byte_bits;
  } in_t;

  // Output transaction: one alphabet character
  typedef struct packed {
    logic [6:0] symbol;
    logic       final_symbol;
  } out_t;

  localparam int GRP_W  = 5;
  localparam int ACC_W  = 12;
  localparam int WORD_W = 15;

  // Classified byte: bits left aligned to three groups, group count, end mark
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        nout;
    logic              eom;
  } ent_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // z-base-32 alphabet as 7-bit ASCII
  localparam logic [6:0] ALPHABET [32] = '{
    7'h79, 7'h62, 7'h6e, 7'h64, 7'h72, 7'h66, 7'h67, 7'h38,
    7'h65, 7'h6a, 7'h6b, 7'h6d, 7'h63, 7'h70, 7'h71, 7'h78,
    7'h6f, 7'h74, 7'h31, 7'h75, 7'h77, 7'h69, 7'h73, 7'h7a,
    7'h61, 7'h33, 7'h34, 7'h35, 7'h68, 7'h37, 7'h36, 7'h39
  };

endpackage

FILE: hdl/zb32e_front.sv
// Front end: accepts bytes, merges held bits and classifies each byte
// into a queue entry. Depends on zb32e_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zb32e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  zb32e_pkg::in_t     in_data,
  input  zb32e_pkg::q_stat_t q_stat,
  output logic               wr_en,
  output zb32e_pkg::ent_t    wr_ent
);

  logic [3:0]                   leftover_bits_r, leftover_bits_nxt;
  logic [2:0]                   leftover_count_r, leftover_count_nxt;
  logic [2:0]                   cnt;
  logic [3:0]                   nbits;
  logic [zb32e_pkg::ACC_W-1:0]  acc;
  logic [3:0]                   lbits;
  logic [3:0]                   tot;
  logic [1:0]                   nout;
  logic [2:0]                   rem;
  logic                         accept;

  // Stall only on a full queue
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept;

  // Merge held bits with the new byte
  always_comb begin
    cnt   = (leftover_count_r > 3'd4) ? 3'd4 : leftover_count_r;
    nbits = {1'b0, cnt} + 4'd8;
    acc   = {leftover_bits_r, in_data.data_byte}
            & 12'((13'd1 << nbits) - 13'd1);
    lbits = (in_data.last_byte_bits > 4'd8) ? 4'd8 : in_data.last_byte_bits;
    tot   = {1'b0, cnt} + lbits;
  end

  // Count the characters this byte releases
  always_comb begin
    if (in_data.end_of_message) begin
      if (tot == 4'd0) begin
        nout = 2'd0;
      end else if (tot <= 4'd5) begin
        nout = 2'd1;
      end else if (tot <= 4'd10) begin
        nout = 2'd2;
      end else begin
        nout = 2'd3;
      end
    end else begin
      nout = (nbits >= 4'd10) ? 2'd2 : 2'd1;
    end
    rem = 3'(nbits - ((nout == 2'd2) ? 4'd10 : 4'd5));
  end

  // Build the queue entry, groups left aligned
  always_comb begin
    wr_ent.word = zb32e_pkg::WORD_W'(acc) << (4'd15 - nbits);
    wr_ent.nout = nout;
    wr_ent.eom  = in_data.end_of_message;
  end

  // Hold the bits that do not yet fill a group; drop them at message end
  always_comb begin
    leftover_bits_nxt  = leftover_bits_r;
    leftover_count_nxt = leftover_count_r;
    if (accept) begin
      if (in_data.end_of_message) begin
        leftover_bits_nxt  = 4'd0;
        leftover_count_nxt = 3'd0;
      end else begin
        leftover_bits_nxt  = acc[3:0] & 4'((5'd1 << rem) - 5'd1);
        leftover_count_nxt = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leftover_bits_r  <= 4'd0;
      leftover_count_r <= 3'd0;
    end else begin
      leftover_bits_r  <= leftover_bits_nxt;
      leftover_count_r <= leftover_count_nxt;
    end
  end

  `ZB_ASSERT_IMP(a_count_range, 1'b1, leftover_count_r <= 3'd4, "held bit count above four")
  `ZB_ASSERT_NXT(a_eom_clears, accept && in_data.end_of_message, leftover_count_r == 3'd0 && leftover_bits_r == 4'd0, "held bits not cleared at message end")

endmodule

FILE: hdl/zb32e_queue.sv
// Short queue of classified bytes between front and back.
// Depends on zb32e_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zb32e_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  zb32e_pkg::ent_t    wr_ent,
  input  logic               rd_en,
  output zb32e_pkg::ent_t    rd_ent,
  output zb32e_pkg::q_stat_t q_stat
);

  zb32e_pkg::ent_t               ent_r [zb32e_pkg::Q_DEPTH];
  logic [zb32e_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [zb32e_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [zb32e_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic                          do_wr, do_rd;

  assign q_stat.full  = (count_r == zb32e_pkg::Q_CNT_W'(zb32e_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_wr        = wr_en && !q_stat.full;
  assign do_rd        = rd_en && !q_stat.empty;
  assign rd_ent       = ent_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries; no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_ent;
    end
  end

  `ZB_ASSERT_IMP(a_no_push_full, wr_en, !q_stat.full, "push into full queue")
  `ZB_ASSERT_IMP(a_ptr_match, 1'b1, (wr_ptr_r - rd_ptr_r) == zb32e_pkg::Q_PTR_W'(count_r), "queue pointers disagree with count")

endmodule

FILE: hdl/zb32e_back.sv
// Back end: walks the groups of each queued entry, maps them through the
// alphabet and drives the output register. Depends on zb32e_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zb32e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  zb32e_pkg::ent_t    rd_ent,
  input  zb32e_pkg::q_stat_t q_stat,
  output logic               rd_en,
  output logic               out_valid,
  input  logic               out_stall,
  output zb32e_pkg::out_t    out_data
);

  logic                         out_valid_r, out_valid_nxt;
  zb32e_pkg::out_t              out_data_r, out_data_nxt;
  logic [1:0]                   idx_r, idx_nxt;
  logic [zb32e_pkg::GRP_W-1:0]  grp;
  logic                         load_ok;
  logic                         last;
  logic                         emit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load_ok   = !out_valid_r || !out_stall;
  assign last      = (idx_r == rd_ent.nout - 2'd1);

  // Select the current group of the head entry
  always_comb begin
    case (idx_r)
      2'd0:    grp = rd_ent.word[14:10];
      2'd1:    grp = rd_ent.word[9:5];
      default: grp = rd_ent.word[4:0];
    endcase
  end

  // Emit one character per free output slot; drop empty entries at once
  always_comb begin
    emit          = !q_stat.empty && (rd_ent.nout != 2'd0) && load_ok;
    rd_en         = !q_stat.empty && ((rd_ent.nout == 2'd0) || (emit && last));
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      idx_nxt                   = last ? 2'd0 : idx_r + 2'd1;
      out_data_nxt.symbol       = zb32e_pkg::ALPHABET[grp];
      out_data_nxt.final_symbol = rd_ent.eom && last;
    end
    if (load_ok) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `ZB_ASSERT_IMP(a_idx_range, 1'b1, idx_r != 2'd3, "group index out of range")
  `ZB_ASSERT_IMP(a_mid_entry, idx_r != 2'd0, !q_stat.empty && idx_r < rd_ent.nout, "group walk without a head entry")

endmodule

FILE: hdl/zbase32_bit_length_encoder_unit.sv
// Top level of the z-base-32 bit-length encoder: front, queue and back.
// Depends on zb32e_pkg, zb32e_front, zb32e_queue and zb32e_back.
//
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | one message byte (zb32e_pkg::in_t)
//   output  | out_valid, out_stall, out_data | one character (zb32e_pkg::out_t)
//
// The front takes one byte per cycle while the four-entry queue has room.
// The back emits one character per cycle while the output is not stalled, so a byte
// holds it for each character it releases (1 to 3), and a byte that releases none is
// dropped from the queue; about 1.6 characters per byte on a long message.
// A byte's first character passes through the queue and then the output register.
// Reset clears the held bits, empties the queue and clears the output valid flag.
// An output stall holds the output register; the queue then fills and stalls the input.
module zbase32_bit_length_encoder_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  zb32e_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output zb32e_pkg::out_t out_data
);

  zb32e_pkg::q_stat_t q_stat;
  zb32e_pkg::ent_t    wr_ent;
  zb32e_pkg::ent_t    rd_ent;
  logic               wr_en;
  logic               rd_en;

  // Classify incoming bytes
  zb32e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .wr_en    (wr_en),
    .wr_ent   (wr_ent)
  );

  // Decouple front and back
  zb32e_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_ent (wr_ent),
    .rd_en  (rd_en),
    .rd_ent (rd_ent),
    .q_stat (q_stat)
  );

  // Emit characters
  zb32e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_ent    (rd_ent),
    .q_stat    (q_stat),
    .rd_en     (rd_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: dv/zbase32_bit_length_encoder_unit_test.sv
// Self-checking bench for the z-base-32 bit-length encoder: directed and random messages.
// Predicts each character from a local alphabet table and a copy of the held-bit state.
// Depends on zb32e_pkg and zbase32_bit_length_encoder_unit.
module zbase32_bit_length_encoder_unit_test;

  localparam string ZB_CHARS = "ybndrfg8ejkmcpqxot1uwisza345h769";
  localparam int STALL_PCT = 15;
  localparam int QUIET_FROM = 180;
  localparam int QUIET_TO = 280;
  localparam int HANG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    zb32e_pkg::in_t item;
    bit             drain;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  zb32e_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  zb32e_pkg::out_t out_data;

  byte_req_t       byte_q[$];
  zb32e_pkg::out_t symbol_q[$];
  int        issued = 0;
  int        pending_syms = 0;
  int        errors = 0;
  int        hang_cycles = 0;
  logic [3:0] held_bits;
  logic [2:0] held_count;
  bit        quiet;

  zbase32_bit_length_encoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // No idling on either side while this window of bytes goes through
  assign quiet = (issued >= QUIET_FROM) && (issued < QUIET_TO);

  // Queue one byte; last_byte_bits of an inner byte is don't-care, so randomise it
  function automatic void add_byte(logic [7:0] b, bit eom, logic [3:0] lb, bit drain);
    byte_req_t r;
    r.item.data_byte = b;
    r.item.end_of_message = eom;
    r.item.last_byte_bits = eom ? lb : 4'($urandom_range(0, 15));
    r.drain = drain;
    byte_q.push_back(r);
  endfunction

  // Expected characters for one accepted byte; advance the held bits
  function automatic void encode_byte(zb32e_pkg::in_t t);
    int unsigned cnt, acc, nbits, nout, lb, stop, grp;
    byte ch;
    zb32e_pkg::out_t c;
    cnt = held_count;
    if (cnt > 4) cnt = 4;
    acc = {held_bits, t.data_byte};
    acc = acc & ((32'd1 << (cnt + 8)) - 1);
    nbits = cnt + 8;
    if (t.end_of_message) begin
      lb = t.last_byte_bits;
      if (lb > 8) lb = 8;
      nout = (cnt + lb + 4) / 5;
    end else begin
      nout = nbits / 5;
    end
    for (int i = 0; i < nout; i++) begin
      stop = 5 * (i + 1);
      grp = (stop <= nbits) ? (acc >> (nbits - stop)) : (acc << (stop - nbits));
      ch = ZB_CHARS[grp & 31];
      c.symbol = ch[6:0];
      c.final_symbol = t.end_of_message && (i + 1 == nout);
      symbol_q.push_back(c);
    end
    if (t.end_of_message) begin
      held_bits = '0;
      held_count = '0;
    end else begin
      held_count = 3'(nbits - 5 * nout);
      held_bits = 4'(acc & ((32'd1 << held_count) - 1));
    end
  endfunction

  // Driver: present the next byte once the previous transaction has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall) begin
      if (byte_q.size() == 0 || (!quiet && $urandom_range(0, 99) < STALL_PCT)) begin
        in_valid <= 1'b0;
      end else if (byte_q[0].drain && (in_valid || pending_syms != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= byte_q[0].item;
        byte_q.pop_front();
        issued <= issued + 1;
      end
    end
  end

  // Monitor: check each character, then predict from any byte taken this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      held_bits = '0;
      held_count = '0;
      pending_syms <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (symbol_q.size() == 0) begin
          $error("unexpected character: symbol %h final_symbol %b",
                 out_data.symbol, out_data.final_symbol);
          errors++;
        end else begin
          if (out_data.symbol !== symbol_q[0].symbol) begin
            $error("symbol: expected %h, actual %h", symbol_q[0].symbol, out_data.symbol);
            errors++;
          end
          if (out_data.final_symbol !== symbol_q[0].final_symbol) begin
            $error("final_symbol: expected %b, actual %b",
                   symbol_q[0].final_symbol, out_data.final_symbol);
            errors++;
          end
          symbol_q.pop_front();
        end
      end
      if (in_valid && !in_stall) encode_byte(in_data);
      pending_syms <= symbol_q.size();
      out_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // Watchdog: give up after a long run of cycles with no transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_cycles <= 0;
      end else begin
        hang_cycles <= hang_cycles + 1;
      end
      if (hang_cycles >= HANG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int len;
    int pick;
    logic [3:0] lb;

    // Single-byte extremes, zero valid bits with nothing held, oversized bit counts
    add_byte(8'hFF, 1'b1, 4'd8, 1'b0);
    add_byte(8'h00, 1'b1, 4'd0, 1'b0);
    add_byte(8'h5A, 1'b1, 4'd15, 1'b0);
    add_byte(8'h96, 1'b1, 4'd9, 1'b0);
    add_byte(8'h01, 1'b1, 4'd7, 1'b0);
    add_byte(8'hC3, 1'b1, 4'd5, 1'b0);
    // Zero valid bits with bits still held
    add_byte(8'hA5, 1'b0, 4'd0, 1'b0);
    add_byte(8'h3C, 1'b1, 4'd0, 1'b0);
    // Four bits held at the end: three characters from the last byte
    add_byte(8'hFF, 1'b0, 4'd0, 1'b0);
    add_byte(8'h00, 1'b0, 4'd0, 1'b0);
    add_byte(8'hFF, 1'b0, 4'd0, 1'b0);
    add_byte(8'h80, 1'b1, 4'd8, 1'b0);
    // Short messages ending on one and a few bits
    add_byte(8'h12, 1'b0, 4'd0, 1'b0);
    add_byte(8'h34, 1'b0, 4'd0, 1'b0);
    add_byte(8'h56, 1'b0, 4'd0, 1'b0);
    add_byte(8'h78, 1'b1, 4'd1, 1'b0);
    add_byte(8'h7E, 1'b0, 4'd0, 1'b0);
    add_byte(8'h81, 1'b1, 4'd3, 1'b0);

    // Random messages, mostly short, a few long; drain before the first and near byte 300
    while (byte_q.size() < 410) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      pick = $urandom_range(0, 19);
      if (pick == 0) lb = 4'd0;
      else if (pick == 1) lb = 4'($urandom_range(9, 15));
      else lb = 4'($urandom_range(1, 8));
      for (int k = 0; k < len; k++) begin
        add_byte(8'($urandom_range(0, 255)), k == len - 1, lb,
                 (k == 0) && (byte_q.size() == 18 || (byte_q.size() > 300 &&
                 byte_q.size() < 310)));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (byte_q.size() != 0 || in_valid || pending_syms != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && symbol_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (symbol_q.size() != 0)
        $error("%0d expected characters never arrived", symbol_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
